@@ rtl/red_blob_projection_locator_defines.svh @@
// Assertion macros shared by the checker of the red blob projection locator.
// Depends on nothing; the asserting file supplies i_clk and i_rst_n.
`ifndef RED_BLOB_PROJECTION_LOCATOR_DEFINES_SVH
`define RED_BLOB_PROJECTION_LOCATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define RBPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rbpl assertion failed");

// Next-cycle implication, disabled in reset
`define RBPL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rbpl assertion failed");

`endif

@@ rtl/rbpl_pkg.sv @@
// Shared types and constants of the red blob projection locator.
// Depends on nothing.
package rbpl_pkg;

    // Smoothing window length and its shift
    localparam int AVG_TAPS  = 4;
    localparam int AVG_SHIFT = 2;

    localparam logic [11:0] CNT_MAX = 12'hFFF;

    // Configuration register indexes
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_START_COL    = 3'd2;
    localparam logic [2:0] CFG_START_ROW    = 3'd3;
    localparam logic [2:0] CFG_MIN_COUNT    = 3'd4;

    // Result status codes
    localparam logic [1:0] STATUS_FOUND      = 2'd0;
    localparam logic [1:0] STATUS_NO_OBJECT  = 2'd1;
    localparam logic [1:0] STATUS_BAD_WINDOW = 2'd2;

    typedef enum logic [2:0] {
        S_INIT,
        S_INIT_WAIT,
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic pix_take;
        logic pix_write;
        logic sweep_start;
        logic load_result;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_busy;
    } t_dp_stat;

endpackage

@@ rtl/rbpl_if.sv @@
// Channel interfaces of the red blob projection locator: pixel, result, config.
// Depends on nothing.
interface rbpl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
    modport source (output valid, blue, green, red, frame_end, input ready);
    modport sink   (input valid, blue, green, red, frame_end, output ready);
endinterface

interface rbpl_res_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [11:0] center_x;
    logic signed [11:0] center_y;
    logic signed [11:0] col_begin;
    logic signed [11:0] col_finish;
    logic signed [11:0] row_begin;
    logic signed [11:0] row_finish;
    modport source (output valid, status, center_x, center_y, col_begin, col_finish,
                    row_begin, row_finish, input ready);
    modport sink   (input valid, status, center_x, center_y, col_begin, col_finish,
                    row_begin, row_finish, output ready);
endinterface

interface rbpl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rbpl_axis.sv @@
// One projection axis: count memory with read-modify-write, plus a sweep that
// smooths, finds the edges and clears the memory. Depends on rbpl_pkg.
module rbpl_axis #(
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [11:0]              i_min_count,
    input  logic                     i_add_rd,
    input  logic [$clog2(DEPTH)-1:0] i_add_addr,
    input  logic                     i_add_en,
    input  logic [11:0]              i_add_val,
    input  logic                     i_add_wr,
    input  logic                     i_sweep_start,
    output logic                     o_busy,
    output logic                     o_rise_found,
    output logic [11:0]              o_rise,
    output logic                     o_fall_found,
    output logic [11:0]              o_fall
);
    localparam int AW = $clog2(DEPTH);
    localparam int T  = rbpl_pkg::AVG_TAPS;
    localparam int SW = 12 + rbpl_pkg::AVG_SHIFT;

    logic [11:0]   r_mem [DEPTH];
    logic [11:0]   r_rd;
    logic          r_add_en;
    logic [AW-1:0] r_add_addr;
    logic [11:0]   r_add_val;

    logic          r_sw_issue;
    logic [AW-1:0] r_sw_addr;
    logic          r_sw_rdv;
    logic [AW-1:0] r_sw_idx;
    logic          r_busy;
    logic [11:0]   r_win [T-1];
    logic [11:0]   r_prev;
    logic          r_rise_found;
    logic [11:0]   r_rise;
    logic          r_fall_found;
    logic [11:0]   r_fall;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wa;
    logic [11:0]   wd;
    logic [12:0]   add_sum;
    logic [SW-1:0] win_sum;
    logic [11:0]   smooth;
    logic          pair_ok;

    // Saturating count update
    assign add_sum = {1'b0, r_rd} + {1'b0, r_add_val};

    // Select memory port use: sweep, or pixel read then write
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_add_addr;
        we      = 1'b0;
        wa      = r_add_addr;
        wd      = add_sum[12] ? rbpl_pkg::CNT_MAX : add_sum[11:0];
        if (r_sw_issue) begin
            rd_en   = 1'b1;
            rd_addr = r_sw_addr;
            we      = 1'b1;
            wa      = r_sw_addr;
            wd      = '0;
        end else if (i_add_rd) begin
            rd_en = 1'b1;
        end else if (i_add_wr && r_add_en) begin
            we = 1'b1;
        end
    end

    // Memory: registered read, old data on same-address write
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    // Hold the pending pixel update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_en <= 1'b0;
        end else if (i_add_rd) begin
            r_add_en <= i_add_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_add_rd) begin
            r_add_addr <= i_add_addr;
            r_add_val  <= i_add_val;
        end
    end

    // Trailing average over the window of the newest words
    always_comb begin
        win_sum = SW'(r_rd);
        for (int i = 0; i < T - 1; i++) begin
            win_sum = win_sum + SW'(r_win[i]);
        end
        smooth  = 12'(win_sum >> rbpl_pkg::AVG_SHIFT);
        pair_ok = (r_sw_idx >= AW'(T)) && (r_sw_idx <= AW'(DEPTH - 2));
    end

    // Advance the sweep and track the first crossings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_issue   <= 1'b0;
            r_sw_rdv     <= 1'b0;
            r_busy       <= 1'b0;
            r_rise_found <= 1'b0;
            r_fall_found <= 1'b0;
        end else begin
            r_sw_rdv <= r_sw_issue;
            if (i_sweep_start) begin
                r_sw_issue   <= 1'b1;
                r_busy       <= 1'b1;
                r_rise_found <= 1'b0;
                r_fall_found <= 1'b0;
            end else if (r_sw_issue && r_sw_addr == AW'(DEPTH - 1)) begin
                r_sw_issue <= 1'b0;
            end
            if (r_sw_rdv) begin
                if (pair_ok && !r_rise_found && r_prev < i_min_count
                        && smooth >= i_min_count) begin
                    r_rise_found <= 1'b1;
                end
                if (pair_ok && !r_fall_found && r_prev >= i_min_count
                        && smooth < i_min_count) begin
                    r_fall_found <= 1'b1;
                end
                if (r_sw_idx == AW'(DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sweep_start) begin
            r_sw_addr <= '0;
        end else if (r_sw_issue) begin
            r_sw_addr <= r_sw_addr + AW'(1);
        end
        r_sw_idx <= r_sw_addr;
        if (r_sw_rdv) begin
            r_win[0] <= r_rd;
            for (int i = 1; i < T - 1; i++) begin
                r_win[i] <= r_win[i-1];
            end
            r_prev <= smooth;
            if (pair_ok && !r_rise_found && r_prev < i_min_count
                    && smooth >= i_min_count) begin
                r_rise <= 12'(r_sw_idx) - 12'(T);
            end
            if (pair_ok && !r_fall_found && r_prev >= i_min_count
                    && smooth < i_min_count) begin
                r_fall <= 12'(r_sw_idx) - 12'(T);
            end
        end
    end

    assign o_busy       = r_busy;
    assign o_rise_found = r_rise_found;
    assign o_rise       = r_rise;
    assign o_fall_found = r_fall_found;
    assign o_fall       = r_fall;

endmodule

@@ rtl/rbpl_datapath.sv @@
// Datapath: config registers, pixel position and classification, both axes and
// the result registers. Depends on rbpl_pkg and rbpl_axis.
module rbpl_datapath #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rbpl_pkg::t_dp_cmd   i_cmd,
    output rbpl_pkg::t_dp_stat  o_stat,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data,
    input  logic [7:0]          i_blue,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_red,
    input  logic                i_frame_end,
    output logic [1:0]          o_status,
    output logic signed [11:0]  o_center_x,
    output logic signed [11:0]  o_center_y,
    output logic signed [11:0]  o_col_begin,
    output logic signed [11:0]  o_col_finish,
    output logic signed [11:0]  o_row_begin,
    output logic signed [11:0]  o_row_finish
);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int RAW = $clog2(MAX_ROWS);

    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic [10:0] r_start_col;
    logic [10:0] r_start_row;
    logic [11:0] r_min_count;
    logic [10:0] r_col;
    logic [10:0] r_row;
    logic [11:0] r_acc;

    logic [1:0]  r_status;
    logic [11:0] r_cx, r_cy, r_cb, r_cf, r_rb, r_rf;

    logic        is_red, row_ok, col_ok, row_end, col_add, row_add;
    logic [12:0] acc_sum;
    logic [11:0] acc_new;
    logic        c_busy, c_rf, c_ff, r_busy_ax, r_rfnd, r_ffnd;
    logic [11:0] c_rise, c_fall, r_rise, r_fall;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 12'd640;
            r_frame_height <= 12'd480;
            r_start_col    <= '0;
            r_start_row    <= '0;
            r_min_count    <= 12'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rbpl_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                rbpl_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                rbpl_pkg::CFG_START_COL:    r_start_col    <= i_cfg_data[10:0];
                rbpl_pkg::CFG_START_ROW:    r_start_row    <= i_cfg_data[10:0];
                rbpl_pkg::CFG_MIN_COUNT:    r_min_count    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify the pixel and decide the count updates
    always_comb begin
        is_red  = ({1'b0, i_red, 1'b0} > 10'(3 * i_blue))
               && ({1'b0, i_red, 1'b0} > 10'(3 * i_green));
        row_ok  = (r_row >= r_start_row) && ({1'b0, r_row} < r_frame_height)
               && (32'(r_row) < MAX_ROWS);
        col_ok  = (r_col >= r_start_col) && ({1'b0, r_col} < r_frame_width)
               && (32'(r_col) < MAX_COLS);
        row_end = ({1'b0, r_col} + 12'd1) >= r_frame_width;
        col_add = is_red && row_ok && col_ok;
        acc_sum = {1'b0, r_acc} + 13'(col_add);
        acc_new = acc_sum[12] ? rbpl_pkg::CNT_MAX : acc_sum[11:0];
        row_add = (row_end || i_frame_end) && (32'(r_row) < MAX_ROWS);
    end

    // Advance position and row accumulator; clear on the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_acc <= '0;
        end else if (i_cmd.pix_take) begin
            if (i_frame_end) begin
                r_col <= '0;
                r_row <= '0;
                r_acc <= '0;
            end else begin
                r_acc <= row_end ? 12'd0 : acc_new;
                r_col <= row_end ? 11'd0 : r_col + 11'd1;
                r_row <= row_end ? r_row + 11'd1 : r_row;
            end
        end
    end

    rbpl_axis #(.DEPTH(MAX_COLS)) u_col_axis (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_count   (r_min_count),
        .i_add_rd      (i_cmd.pix_take),
        .i_add_addr    (CAW'({1'b0, r_col})),
        .i_add_en      (col_add),
        .i_add_val     (12'd1),
        .i_add_wr      (i_cmd.pix_write),
        .i_sweep_start (i_cmd.sweep_start),
        .o_busy        (c_busy),
        .o_rise_found  (c_rf),
        .o_rise        (c_rise),
        .o_fall_found  (c_ff),
        .o_fall        (c_fall)
    );

    rbpl_axis #(.DEPTH(MAX_ROWS)) u_row_axis (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_count   (r_min_count),
        .i_add_rd      (i_cmd.pix_take),
        .i_add_addr    (RAW'({1'b0, r_row})),
        .i_add_en      (row_add),
        .i_add_val     (acc_new),
        .i_add_wr      (i_cmd.pix_write),
        .i_sweep_start (i_cmd.sweep_start),
        .o_busy        (r_busy_ax),
        .o_rise_found  (r_rfnd),
        .o_rise        (r_rise),
        .o_fall_found  (r_ffnd),
        .o_fall        (r_fall)
    );

    assign o_stat.sweep_busy = c_busy || r_busy_ax;

    // Midpoint, truncating toward zero
    function automatic logic [11:0] midpoint(input logic [11:0] b, input logic [11:0] f);
        logic signed [12:0] d;
        logic signed [12:0] h;
        d = $signed({1'b0, f}) - $signed({1'b0, b});
        h = (d + $signed({12'd0, d[12]})) >>> 1;
        return 12'(h + $signed({1'b0, b}));
    endfunction

    // Form the result
    always_ff @(posedge i_clk) begin
        logic        cr_ok, rr_ok;
        logic [11:0] cb, rb;
        if (i_cmd.load_result) begin
            cr_ok = c_rf || (c_ff && c_fall != 12'd0);
            rr_ok = r_rfnd || (r_ffnd && r_fall != 12'd0);
            cb    = c_rf ? c_rise : 12'd0;
            rb    = r_rfnd ? r_rise : 12'd0;
            if ((32'(r_frame_width) > MAX_COLS) || (32'(r_frame_height) > MAX_ROWS)
                    || ({2'b0, r_start_col} + {1'b0, r_min_count}) > {1'b0, r_frame_width}
                    || ({2'b0, r_start_row} + {1'b0, r_min_count}) > {1'b0, r_frame_height})
            begin
                r_status <= rbpl_pkg::STATUS_BAD_WINDOW;
                r_cx <= '1; r_cy <= '1; r_cb <= '1; r_cf <= '1; r_rb <= '1; r_rf <= '1;
            end else begin
                r_cb <= cr_ok ? cb : '1;
                r_cf <= c_ff ? c_fall : '1;
                r_rb <= rr_ok ? rb : '1;
                r_rf <= r_ffnd ? r_fall : '1;
                r_cx <= (cr_ok && c_ff) ? midpoint(cb, c_fall) : '1;
                r_cy <= (rr_ok && r_ffnd) ? midpoint(rb, r_fall) : '1;
                r_status <= (cr_ok && c_ff && rr_ok && r_ffnd) ? rbpl_pkg::STATUS_FOUND
                                                               : rbpl_pkg::STATUS_NO_OBJECT;
            end
        end
    end

    assign o_status     = r_status;
    assign o_center_x   = $signed(r_cx);
    assign o_center_y   = $signed(r_cy);
    assign o_col_begin  = $signed(r_cb);
    assign o_col_finish = $signed(r_cf);
    assign o_row_begin  = $signed(r_rb);
    assign o_row_finish = $signed(r_rf);

endmodule

@@ rtl/rbpl_ctrl.sv @@
// Controller state machine: pixel handshake, sweep sequencing, result valid.
// Depends on rbpl_pkg.
module rbpl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_frame_end,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output rbpl_pkg::t_dp_cmd  o_cmd,
    input  rbpl_pkg::t_dp_stat i_stat
);
    rbpl_pkg::t_state r_state, n_state;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbpl_pkg::S_INIT;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            rbpl_pkg::S_INIT: begin
                o_cmd.sweep_start = 1'b1;
                n_state = rbpl_pkg::S_INIT_WAIT;
            end
            rbpl_pkg::S_INIT_WAIT: begin
                if (!i_stat.sweep_busy) n_state = rbpl_pkg::S_IDLE;
            end
            rbpl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.pix_take = 1'b1;
                    n_last  = i_in_frame_end;
                    n_state = rbpl_pkg::S_UPDATE;
                end
            end
            rbpl_pkg::S_UPDATE: begin
                o_cmd.pix_write = 1'b1;
                n_state = r_last ? rbpl_pkg::S_SCAN : rbpl_pkg::S_IDLE;
            end
            rbpl_pkg::S_SCAN: begin
                o_cmd.sweep_start = 1'b1;
                n_state = rbpl_pkg::S_SCAN_WAIT;
            end
            rbpl_pkg::S_SCAN_WAIT: begin
                if (!i_stat.sweep_busy) n_state = rbpl_pkg::S_DONE;
            end
            rbpl_pkg::S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = rbpl_pkg::S_IDLE;
                end
            end
            default: n_state = rbpl_pkg::S_INIT;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/red_blob_projection_locator.sv @@
// Red blob locator: per-row and per-column red pixel projections, smoothed,
// searched for threshold crossings. Depends on rbpl_pkg, rbpl_if, rbpl_ctrl, rbpl_datapath.
//
// Each pixel word is first read from its column and row counts in the count
// memories and then written back; no new pixel word is taken until the write
// is done. The pixel carrying frame_end starts a sweep over both memories,
// one entry per cycle, that smooths, finds the edges and clears the entries;
// when it ends, one result word is offered. The result waits in an output
// register while the next frame flows in. After reset the same sweep runs
// once to clear the memories, during which no pixel is taken; configuration
// writes are taken at any time.
module red_blob_projection_locator #(
    parameter int MAX_COLS = 2048,
    parameter int MAX_ROWS = 2048
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rbpl_pix_if.sink   i_pix,
    rbpl_res_if.source o_res,
    rbpl_cfg_if.sink   i_cfg
);
    rbpl_pkg::t_dp_cmd  cmd;
    rbpl_pkg::t_dp_stat stat;

    assign i_cfg.ready = 1'b1;

    rbpl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_pix.valid),
        .i_in_frame_end (i_pix.frame_end),
        .o_in_ready     (i_pix.ready),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_cmd          (cmd),
        .i_stat         (stat)
    );

    rbpl_datapath #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_blue       (i_pix.blue),
        .i_green      (i_pix.green),
        .i_red        (i_pix.red),
        .i_frame_end  (i_pix.frame_end),
        .o_status     (o_res.status),
        .o_center_x   (o_res.center_x),
        .o_center_y   (o_res.center_y),
        .o_col_begin  (o_res.col_begin),
        .o_col_finish (o_res.col_finish),
        .o_row_begin  (o_res.row_begin),
        .o_row_finish (o_res.row_finish)
    );

endmodule

@@ rtl/rbpl_checker.sv @@
// Port-level checker for the red blob projection locator, bound to the top.
// Depends on rbpl_pkg and red_blob_projection_locator_defines.svh.
`include "red_blob_projection_locator_defines.svh"

module rbpl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_status,
    input logic [11:0] i_center_x,
    input logic [11:0] i_center_y,
    input logic [11:0] i_col_begin,
    input logic [11:0] i_row_finish
);
    // A stalled result word stays offered
    `RBPL_ASSERT_NXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid)

    // A stalled result word keeps its center_x and status
    `RBPL_ASSERT_NXT(a_res_stable, i_res_valid && !i_res_ready, $stable(i_center_x) && $stable(i_status))

    // A found object has both midpoints non-negative
    `RBPL_ASSERT_IMP(a_found_ok, i_res_valid && i_status == rbpl_pkg::STATUS_FOUND, !i_center_x[11] && !i_center_y[11])

    // A bad window reports col_begin and row_finish as all ones
    `RBPL_ASSERT_IMP(a_bad_win, i_res_valid && i_status == rbpl_pkg::STATUS_BAD_WINDOW, i_col_begin == 12'hFFF && i_row_finish == 12'hFFF)

endmodule

bind red_blob_projection_locator rbpl_checker u_rbpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_center_x   (o_res.center_x),
    .i_center_y   (o_res.center_y),
    .i_col_begin  (o_res.col_begin),
    .i_row_finish (o_res.row_finish)
);
